### hdl/harris_corner_response_assert.svh
// assertion macros used by the harris corner response checker
// no dependencies; included by hcr_checker.sv, the file that carries the concurrent assertions
`ifndef HARRIS_CORNER_RESPONSE_ASSERT_SVH
`define HARRIS_CORNER_RESPONSE_ASSERT_SVH

// same-cycle implication
`define HCR_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hcr assertion failed");

// next-cycle implication
`define HCR_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hcr assertion failed");

`endif

### hdl/hcr_pkg.sv
// types, constants and codes for the harris corner response block
// no dependencies; imported by every module and interface of the block
package hcr_pkg;

   localparam int MAX_LINE_WIDTH = 1024;
   localparam int COL_W          = $clog2(MAX_LINE_WIDTH);
   localparam int RING_ROWS      = 8;
   localparam int SLOT_W         = $clog2(RING_ROWS);
   localparam int MEM_AW         = SLOT_W + COL_W;
   localparam int MEM_DEPTH      = RING_ROWS * MAX_LINE_WIDTH;
   localparam int PIX_W          = 8;
   localparam int GEOM_W         = 11;
   localparam int POS_W          = 21;
   localparam int PEND_W         = 12;
   localparam int NBHD           = 5;
   localparam int WIN_TAPS       = NBHD * NBHD;
   localparam int TAP_W          = $clog2(WIN_TAPS);
   localparam int GRAD_W         = 11;
   localparam int SQ_W           = 2 * GRAD_W;
   localparam int SUM_W          = 24;
   localparam int SXY_W          = 25;
   localparam int RESP_W         = 47;
   localparam int WEIGHT_W       = 16;
   localparam int COORD_W        = 10;
   localparam int CSR_IDX_W      = 2;
   localparam int CSR_DATA_W     = 47;
   localparam int RV_W           = 51;

   localparam logic [RESP_W-1:0] RESP_MAX = {RESP_W{1'b1}};

   localparam logic CMD_PIXEL = 1'b0;
   localparam logic CMD_FLUSH = 1'b1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FRAME_WIDTH,
      CSR_FRAME_HEIGHT,
      CSR_RESPONSE_THRESHOLD,
      CSR_TRACE_WEIGHT
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_FILL,
      ST_GRAD,
      ST_SUM,
      ST_ISSUE
   } seq_state_type;

   typedef struct packed {
      logic              wr_en;
      logic [MEM_AW-1:0] wr_addr;
      logic [PIX_W-1:0]  wr_data;
      logic              rd_en;
      logic [MEM_AW-1:0] rd_addr;
   } line_access_type;

   typedef struct packed {
      logic               valid;
      logic               border;
      logic [SUM_W-1:0]   sxx;
      logic [SUM_W-1:0]   syy;
      logic [SXY_W-1:0]   sxy;
      logic [COORD_W-1:0] row;
      logic [COORD_W-1:0] col;
      logic               frame_end;
   } sum_job_type;

   typedef struct packed {
      logic               border;
      logic [COORD_W-1:0] row;
      logic [COORD_W-1:0] col;
      logic               frame_end;
   } calc_meta_type;

   typedef struct packed {
      logic               valid;
      logic [RESP_W-1:0]  response;
      logic               is_corner;
      logic [COORD_W-1:0] row;
      logic [COORD_W-1:0] col;
      logic               frame_end;
   } calc_result_type;

endpackage

### hdl/hcr_req_if.sv
// request and response channel interfaces of the harris corner response block
// depends on hcr_pkg
interface hcr_req_if import hcr_pkg::*; ;
   logic             valid;
   logic             ready;
   logic             cmd;
   logic [PIX_W-1:0] gray_pixel;
   modport source (output valid, cmd, gray_pixel, input ready);
   modport sink (input valid, cmd, gray_pixel, output ready);
endinterface

interface hcr_rsp_if import hcr_pkg::*; ;
   logic               valid;
   logic               ready;
   logic [RESP_W-1:0]  response;
   logic               is_corner;
   logic [COORD_W-1:0] pixel_row;
   logic [COORD_W-1:0] pixel_col;
   logic               frame_end;
   modport source (output valid, response, is_corner, pixel_row, pixel_col, frame_end,
                   input ready);
   modport sink (input valid, response, is_corner, pixel_row, pixel_col, frame_end,
                 output ready);
endinterface

### hdl/hcr_line_store.sv
// ring of pixel lines: one write port, one registered read port
// depends on hcr_pkg
module hcr_line_store import hcr_pkg::*; (
   input  logic             clock,
   input  line_access_type  acc,
   output logic [PIX_W-1:0] rd_data_ff
);

   logic [PIX_W-1:0] mem [MEM_DEPTH];

   always_ff @(posedge clock) begin
      if (acc.wr_en) begin
         mem[acc.wr_addr] <= acc.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (acc.rd_en) begin
         rd_data_ff <= mem[acc.rd_addr];
      end
   end

endmodule

### hdl/hcr_sequencer.sv
// raster bookkeeping, neighborhood fetch from the line store and
// gradient product sums; depends on hcr_pkg
module hcr_sequencer import hcr_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              restart,
   input  logic [GEOM_W-1:0] width_eff,
   input  logic [GEOM_W-1:0] height_eff,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_cmd,
   input  logic [PIX_W-1:0]  req_pixel,
   input  logic              down_busy,
   output line_access_type   acc,
   input  logic [PIX_W-1:0]  rd_data,
   output sum_job_type       job
);

   seq_state_type state_ff, state_in;

   logic [COL_W-1:0]  in_col_ff, out_col_ff, jcol_ff;
   logic [GEOM_W-1:0] in_row_ff, out_row_ff, jrow_ff;
   logic [SLOT_W-1:0] in_slot_ff, out_slot_ff, jslot_ff;
   logic [POS_W-1:0]  in_pos_ff;
   logic [PEND_W-1:0] pending_ff;
   logic              jend_ff, jborder_ff;
   logic [2:0]        ri_ff, ci_ff, ri_eff, ci_eff;
   logic [1:0]        gr_ff, gc_ff;
   logic              rvalid_ff, gvalid_ff;
   logic [PIX_W-1:0]  win_ff [WIN_TAPS];
   logic signed [GRAD_W-1:0] gx_ff, gy_ff, gx_in, gy_in;
   logic signed [GRAD_W-1:0] pv [3][3];
   logic signed [SQ_W-1:0]   sq_x, sq_y, sq_xy;
   logic [SUM_W-1:0]  sxx_ff, syy_ff;
   logic [SXY_W-1:0]  sxy_ff;

   logic [GEOM_W-1:0] w_m1, w_m2, h_m1, h_m2, rd_col_full;
   logic [PEND_W-1:0] lag;
   logic [TAP_W-1:0]  base;
   logic [SLOT_W-1:0] rd_slot;
   logic accept, is_pixel, emit, in_col_last, in_row_last, out_col_last, out_row_last;
   logic rd_last, g_last, rd_en, g_en, acc_clr, issue;

   assign w_m1 = width_eff - GEOM_W'(1);
   assign w_m2 = width_eff - GEOM_W'(2);
   assign h_m1 = height_eff - GEOM_W'(1);
   assign h_m2 = height_eff - GEOM_W'(2);
   assign lag  = {width_eff, 1'b0} + PEND_W'(2);

   assign accept       = req_valid && req_ready;
   assign is_pixel     = (req_cmd == CMD_PIXEL);
   assign in_col_last  = ({1'b0, in_col_ff} == w_m1);
   assign in_row_last  = (in_row_ff == h_m1);
   assign out_col_last = ({1'b0, out_col_ff} == w_m1);
   assign out_row_last = (out_row_ff == h_m1);
   // a flush answers only what belongs to a fully received frame
   assign emit = is_pixel ? (pending_ff >= lag) : (POS_W'(pending_ff) > in_pos_ff);

   // reflect-101 at the outer ring of the 5x5 neighborhood folds onto the center
   always_comb begin
      ri_eff = ri_ff;
      ci_eff = ci_ff;
      if ((ri_ff == 3'd0 && jrow_ff == GEOM_W'(1)) || (ri_ff == 3'd4 && jrow_ff == h_m2)) begin
         ri_eff = 3'd2;
      end
      if ((ci_ff == 3'd0 && jcol_ff == COL_W'(1)) ||
          (ci_ff == 3'd4 && {1'b0, jcol_ff} == w_m2)) begin
         ci_eff = 3'd2;
      end
   end

   assign rd_slot     = jslot_ff + SLOT_W'(ri_eff) + SLOT_W'(RING_ROWS - 2);
   assign rd_col_full = {1'b0, jcol_ff} + GEOM_W'(ci_eff) - GEOM_W'(2);
   assign rd_last     = (ri_ff == 3'd4) && (ci_ff == 3'd4);
   assign g_last      = (gr_ff == 2'd2) && (gc_ff == 2'd2);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && emit) begin
               state_in = (out_row_ff == '0 || out_row_last || out_col_ff == '0 ||
                           out_col_last) ? ST_ISSUE : ST_READ;
            end
         end
         ST_READ: begin
            if (rd_last) state_in = ST_FILL;
         end
         ST_FILL: state_in = ST_GRAD;
         ST_GRAD: begin
            if (g_last) state_in = ST_SUM;
         end
         ST_SUM: state_in = ST_ISSUE;
         ST_ISSUE: begin
            if (!down_busy) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = (state_ff == ST_IDLE);
      rd_en     = (state_ff == ST_READ);
      g_en      = (state_ff == ST_GRAD);
      acc_clr   = (state_ff == ST_FILL);
      issue     = (state_ff == ST_ISSUE) && !down_busy;
   end

   always_comb begin
      acc.wr_en   = accept && is_pixel;
      acc.wr_addr = {in_slot_ff, in_col_ff};
      acc.wr_data = req_pixel;
      acc.rd_en   = rd_en;
      acc.rd_addr = {rd_slot, rd_col_full[COL_W-1:0]};
   end

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         in_col_ff   <= '0;
         in_row_ff   <= '0;
         in_slot_ff  <= '0;
         in_pos_ff   <= '0;
         pending_ff  <= '0;
         out_col_ff  <= '0;
         out_row_ff  <= '0;
         out_slot_ff <= '0;
      end else if (accept) begin
         if (is_pixel) begin
            in_col_ff <= in_col_last ? '0 : in_col_ff + COL_W'(1);
            in_pos_ff <= (in_col_last && in_row_last) ? '0 : in_pos_ff + POS_W'(1);
            if (in_col_last) begin
               in_slot_ff <= in_slot_ff + SLOT_W'(1);
               in_row_ff  <= in_row_last ? '0 : in_row_ff + GEOM_W'(1);
            end
            if (!emit) pending_ff <= pending_ff + PEND_W'(1);
         end else if (emit) begin
            pending_ff <= pending_ff - PEND_W'(1);
         end
         if (emit) begin
            out_col_ff <= out_col_last ? '0 : out_col_ff + COL_W'(1);
            if (out_col_last) begin
               out_slot_ff <= out_slot_ff + SLOT_W'(1);
               out_row_ff  <= out_row_last ? '0 : out_row_ff + GEOM_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && emit) begin
         jrow_ff    <= out_row_ff;
         jcol_ff    <= out_col_ff;
         jslot_ff   <= out_slot_ff;
         jend_ff    <= out_row_last && out_col_last;
         jborder_ff <= (out_row_ff == '0) || out_row_last || (out_col_ff == '0) || out_col_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || state_ff == ST_IDLE) begin
         ri_ff <= '0;
         ci_ff <= '0;
         gr_ff <= '0;
         gc_ff <= '0;
      end else begin
         if (rd_en) begin
            ci_ff <= (ci_ff == 3'd4) ? 3'd0 : ci_ff + 3'd1;
            if (ci_ff == 3'd4) ri_ff <= ri_ff + 3'd1;
         end
         if (g_en) begin
            gc_ff <= (gc_ff == 2'd2) ? 2'd0 : gc_ff + 2'd1;
            if (gc_ff == 2'd2) gr_ff <= gr_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rvalid_ff <= 1'b0;
         gvalid_ff <= 1'b0;
      end else begin
         rvalid_ff <= rd_en;
         gvalid_ff <= g_en;
      end
   end

   // neighborhood fills in raster order: tap = row * 5 + col
   always_ff @(posedge clock) begin
      if (rvalid_ff) begin
         for (int i = 0; i < WIN_TAPS - 1; i++) begin
            win_ff[i] <= win_ff[i+1];
         end
         win_ff[WIN_TAPS-1] <= rd_data;
      end
   end

   assign base = {1'b0, gr_ff, 2'b00} + TAP_W'(gr_ff) + TAP_W'(gc_ff);

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         for (int b = 0; b < 3; b++) begin
            pv[a][b] = $signed({3'b000, win_ff[base + TAP_W'(a * NBHD + b)]});
         end
      end
      gx_in = (pv[0][2] - pv[0][0]) + ((pv[1][2] - pv[1][0]) <<< 1) + (pv[2][2] - pv[2][0]);
      gy_in = (pv[2][0] - pv[0][0]) + ((pv[2][1] - pv[0][1]) <<< 1) + (pv[2][2] - pv[0][2]);
   end

   always_ff @(posedge clock) begin
      if (g_en) begin
         gx_ff <= gx_in;
         gy_ff <= gy_in;
      end
   end

   assign sq_x  = gx_ff * gx_ff;
   assign sq_y  = gy_ff * gy_ff;
   assign sq_xy = gx_ff * gy_ff;

   always_ff @(posedge clock) begin
      if (acc_clr) begin
         sxx_ff <= '0;
         syy_ff <= '0;
         sxy_ff <= '0;
      end else if (gvalid_ff) begin
         sxx_ff <= sxx_ff + {3'b000, sq_x[SQ_W-2:0]};
         syy_ff <= syy_ff + {3'b000, sq_y[SQ_W-2:0]};
         sxy_ff <= sxy_ff + {{(SXY_W-SQ_W){sq_xy[SQ_W-1]}}, sq_xy};
      end
   end

   always_comb begin
      job.valid     = issue;
      job.border    = jborder_ff;
      job.sxx       = sxx_ff;
      job.syy       = syy_ff;
      job.sxy       = sxy_ff;
      job.row       = jrow_ff[COORD_W-1:0];
      job.col       = jcol_ff;
      job.frame_end = jend_ff;
   end

endmodule

### hdl/hcr_response_calc.sv
// four-stage pipeline: det - k * trace^2, then threshold and clamp
// depends on hcr_pkg
module hcr_response_calc import hcr_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  sum_job_type         job,
   input  logic [RESP_W-1:0]   threshold,
   input  logic [WEIGHT_W-1:0] weight,
   output logic                busy,
   output calc_result_type     res
);

   logic [3:0]          v_ff;
   calc_meta_type       meta_ff [4];
   logic [2*SUM_W-1:0]  p1_ff, p2_ff, det_ff, det3_ff;
   logic [SXY_W:0]      t_ff;
   logic [2*SXY_W-1:0]  sq_sxy, t2_ff;
   logic [41:0]         kh_ff;
   logic [39:0]         kl_ff;
   logic [49:0]         kterm;
   logic signed [RV_W-1:0] rv_ff, rv_in;
   logic                corner;

   assign sq_sxy = (2*SXY_W)'($signed(job.sxy) * $signed(job.sxy));

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= {v_ff[2:0], job.valid};
      end
   end

   always_ff @(posedge clock) begin
      meta_ff[0] <= '{border: job.border, row: job.row, col: job.col,
                      frame_end: job.frame_end};
      for (int i = 1; i < 4; i++) begin
         meta_ff[i] <= meta_ff[i-1];
      end
      // stage 1
      p1_ff <= job.sxx * job.syy;
      p2_ff <= sq_sxy[2*SUM_W-1:0];
      t_ff  <= {1'b0, job.sxx} + {1'b0, job.syy};
      // stage 2
      det_ff <= p1_ff - p2_ff;
      t2_ff  <= t_ff * t_ff;
      // stage 3: weight times trace^2 split in two partial products
      kh_ff   <= weight * t2_ff[49:24];
      kl_ff   <= weight * t2_ff[23:0];
      det3_ff <= det_ff;
      // stage 4
      rv_ff <= rv_in;
   end

   assign kterm = {kh_ff, 8'b0} + {26'b0, kl_ff[39:16]};
   assign rv_in = $signed({3'b000, det3_ff}) - $signed({1'b0, kterm});

   assign corner = !meta_ff[3].border && (rv_ff > $signed({4'b0000, threshold}));
   assign busy   = |v_ff;

   always_comb begin
      res.valid     = v_ff[3];
      res.is_corner = corner;
      res.row       = meta_ff[3].row;
      res.col       = meta_ff[3].col;
      res.frame_end = meta_ff[3].frame_end;
      if (!corner) begin
         res.response = '0;
      end else if (rv_ff > $signed({4'b0000, RESP_MAX})) begin
         res.response = RESP_MAX;
      end else begin
         res.response = rv_ff[RESP_W-1:0];
      end
   end

endmodule

### hdl/harris_corner_response.sv
// channel  | dir | payload
// req_ch   | in  | cmd (pixel or flush), gray_pixel
// rsp_ch   | out | response, is_corner, pixel_row, pixel_col, frame_end
// csr_*    | in  | write enable, register index, write data
// a request without a result leaves the sequencer idle; one with an interior result holds
// the input through accept, 5x5 line store reads, fill, 3x3 gradient steps, sum, issue and
// shows on rsp after the response pipeline and output register; a border result skips to issue
// issue waits while the response pipeline or the output register is busy, holding off requests
// the next request is taken while a result waits in the output register
// synchronous active-high reset; line store contents are not cleared
// depends on hcr_pkg, hcr_req_if, hcr_line_store, hcr_sequencer, hcr_response_calc
module harris_corner_response import hcr_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   hcr_req_if.sink               req_ch,
   hcr_rsp_if.source             rsp_ch,
   input  logic                  csr_wen,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic [GEOM_W-1:0]   frame_width_ff, frame_height_ff, width_eff, height_eff;
   logic [RESP_W-1:0]   threshold_ff;
   logic [WEIGHT_W-1:0] weight_ff;
   logic                restart, calc_busy, down_busy;
   line_access_type     acc;
   logic [PIX_W-1:0]    rd_data;
   sum_job_type         job;
   calc_result_type     res;

   logic               rsp_valid_ff;
   logic [RESP_W-1:0]  response_ff;
   logic               is_corner_ff, frame_end_ff;
   logic [COORD_W-1:0] row_ff, col_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= GEOM_W'(640);
         frame_height_ff <= GEOM_W'(480);
         threshold_ff    <= RESP_W'(10000);
         weight_ff       <= WEIGHT_W'(2621);
      end else if (csr_wen) begin
         unique case (csr_index_type'(csr_index))
            CSR_FRAME_WIDTH:        frame_width_ff  <= csr_wdata[GEOM_W-1:0];
            CSR_FRAME_HEIGHT:       frame_height_ff <= csr_wdata[GEOM_W-1:0];
            CSR_RESPONSE_THRESHOLD: threshold_ff    <= csr_wdata[RESP_W-1:0];
            CSR_TRACE_WEIGHT:       weight_ff       <= csr_wdata[WEIGHT_W-1:0];
         endcase
      end
   end

   // a write to the frame width or height restarts the stream
   assign restart = csr_wen && (csr_index_type'(csr_index) == CSR_FRAME_WIDTH ||
                                csr_index_type'(csr_index) == CSR_FRAME_HEIGHT);

   always_comb begin
      width_eff = frame_width_ff;
      if (frame_width_ff < GEOM_W'(3)) begin
         width_eff = GEOM_W'(3);
      end else if (frame_width_ff > GEOM_W'(MAX_LINE_WIDTH)) begin
         width_eff = GEOM_W'(MAX_LINE_WIDTH);
      end
      height_eff = (frame_height_ff < GEOM_W'(3)) ? GEOM_W'(3) : frame_height_ff;
   end

   assign down_busy = rsp_valid_ff || calc_busy;

   hcr_line_store u_line_store (
      .clock      (clock),
      .acc        (acc),
      .rd_data_ff (rd_data)
   );

   hcr_sequencer u_sequencer (
      .clock      (clock),
      .reset      (reset),
      .restart    (restart),
      .width_eff  (width_eff),
      .height_eff (height_eff),
      .req_valid  (req_ch.valid),
      .req_ready  (req_ch.ready),
      .req_cmd    (req_ch.cmd),
      .req_pixel  (req_ch.gray_pixel),
      .down_busy  (down_busy),
      .acc        (acc),
      .rd_data    (rd_data),
      .job        (job)
   );

   hcr_response_calc u_response_calc (
      .clock     (clock),
      .reset     (reset),
      .job       (job),
      .threshold (threshold_ff),
      .weight    (weight_ff),
      .busy      (calc_busy),
      .res       (res)
   );

   // a job is issued only with the output register empty
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res.valid) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (res.valid) begin
         response_ff  <= res.response;
         is_corner_ff <= res.is_corner;
         row_ff       <= res.row;
         col_ff       <= res.col;
         frame_end_ff <= res.frame_end;
      end
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.response  = response_ff;
   assign rsp_ch.is_corner = is_corner_ff;
   assign rsp_ch.pixel_row = row_ff;
   assign rsp_ch.pixel_col = col_ff;
   assign rsp_ch.frame_end = frame_end_ff;

endmodule

### hdl/hcr_checker.sv
// port-level checks of the harris corner response block, bound to the top level
// depends on hcr_pkg and harris_corner_response_assert.svh
`include "harris_corner_response_assert.svh"

module hcr_checker import hcr_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [RESP_W-1:0] rsp_response,
   input logic              rsp_is_corner
);

   `HCR_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `HCR_ASSERT_IMP(a_corner_nonzero, clock, reset, rsp_valid, rsp_is_corner == (rsp_response != '0))
   `HCR_ASSERT_IMP(a_quiet_after_reset, clock, reset, $fell(reset), !rsp_valid)

endmodule

bind harris_corner_response hcr_checker u_hcr_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .rsp_response  (rsp_ch.response),
   .rsp_is_corner (rsp_ch.is_corner)
);

### dv/harris_corner_response_test.sv
// self-checking testbench for harris_corner_response: pixel frames go in through req_ch,
// a local corner response predictor checks every response on rsp_ch field by field
// depends on hcr_pkg, hcr_req_if, hcr_rsp_if and harris_corner_response
`timescale 1ns / 100ps

module harris_corner_response_test;
   import hcr_pkg::*;

   localparam longint RESP_LIMIT = 64'h0000_7FFF_FFFF_FFFF;
   localparam int     DRAIN_CYCLES = 60;

   typedef struct packed {
      logic [RESP_W-1:0]  response;
      logic               is_corner;
      logic [COORD_W-1:0] row;
      logic [COORD_W-1:0] col;
      logic               frame_end;
   } corner_result_type;

   logic clock;
   logic reset;
   logic                  csr_wen;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   hcr_req_if req_ch();
   hcr_rsp_if rsp_ch();

   harris_corner_response u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // predictor state
   logic [PIX_W-1:0] line_rows [RING_ROWS][MAX_LINE_WIDTH];
   int unsigned      cfg_width, cfg_height, cfg_weight;
   longint unsigned  cfg_threshold;
   int unsigned      in_row, in_col, out_pos, in_slot, out_slot, backlog;

   corner_result_type expected_responses[$];
   int error_count;
   int request_count;
   int req_max_gap;
   int rsp_max_gap;
   int hold_left;
   int stall_left;
   int tile_lo, tile_hi;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #40_000_000;
      $display("simulation failed");
      $finish;
   end

   task automatic report_mismatch(input string what);
      error_count++;
      $display("mismatch at %0t: %s", $realtime, what);
   endtask

   function automatic int active_width();
      if (cfg_width < 3) return 3;
      if (cfg_width > MAX_LINE_WIDTH) return MAX_LINE_WIDTH;
      return cfg_width;
   endfunction

   function automatic int active_height();
      return (cfg_height < 3) ? 3 : cfg_height;
   endfunction

   function automatic void restart_stream();
      in_row = 0;
      in_col = 0;
      out_pos = 0;
      in_slot = 0;
      out_slot = 0;
      backlog = 0;
   endfunction

   function automatic int mirror(input int x, input int n);
      if (x < 0) return -x;
      if (x >= n) return 2 * n - 2 - x;
      return x;
   endfunction

   function automatic longint stored_pixel(input int rr, input int cc, input int orow);
      int slot;
      slot = (int'(out_slot) + RING_ROWS + rr - orow) % RING_ROWS;
      return longint'({56'b0, line_rows[slot][cc]});
   endfunction

   function automatic void sobel(input int gr, input int gc, input int orow, input int h,
                                 input int w, output longint gx, output longint gy);
      int rm, rp, cm, cp;
      rm = mirror(gr - 1, h);
      rp = mirror(gr + 1, h);
      cm = mirror(gc - 1, w);
      cp = mirror(gc + 1, w);
      gx = (stored_pixel(rm, cp, orow) - stored_pixel(rm, cm, orow))
         + 2 * (stored_pixel(gr, cp, orow) - stored_pixel(gr, cm, orow))
         + (stored_pixel(rp, cp, orow) - stored_pixel(rp, cm, orow));
      gy = (stored_pixel(rp, cm, orow) - stored_pixel(rm, cm, orow))
         + 2 * (stored_pixel(rp, gc, orow) - stored_pixel(rm, gc, orow))
         + (stored_pixel(rp, cp, orow) - stored_pixel(rm, cp, orow));
   endfunction

   // response of the next output pixel; advances the output position
   function automatic corner_result_type next_corner_response();
      int w, h, r, c, dr, dc;
      int unsigned total;
      longint sxx, syy, sxy, gx, gy, det, rv;
      longint unsigned tr, tr2, kterm, k;
      corner_result_type res;
      w = active_width();
      h = active_height();
      total = w * h;
      r = out_pos / w;
      c = out_pos % w;
      res = '0;
      if (r >= 1 && r + 1 < h && c >= 1 && c + 1 < w) begin
         sxx = 0;
         syy = 0;
         sxy = 0;
         for (dr = -1; dr <= 1; dr++)
            for (dc = -1; dc <= 1; dc++) begin
               sobel(r + dr, c + dc, r, h, w, gx, gy);
               sxx += gx * gx;
               syy += gy * gy;
               sxy += gx * gy;
            end
         det = sxx * syy - sxy * sxy;
         tr = longint'(sxx + syy);
         tr2 = tr * tr;
         k = cfg_weight;
         kterm = k * (tr2 >> 16) + ((k * (tr2 & 64'hFFFF)) >> 16);
         rv = det - longint'(kterm);
         if (rv > longint'(cfg_threshold)) begin
            res.is_corner = 1'b1;
            res.response = (rv > RESP_LIMIT) ? RESP_MAX : rv[RESP_W-1:0];
         end
      end
      res.row = r[COORD_W-1:0];
      res.col = c[COORD_W-1:0];
      res.frame_end = (out_pos + 1 == total);
      if (c == w - 1) out_slot = (out_slot + 1) % RING_ROWS;
      out_pos++;
      if (out_pos >= total) out_pos = 0;
      backlog--;
      return res;
   endfunction

   function automatic void predict_request(input logic cmd, input logic [PIX_W-1:0] px);
      int w, h;
      int unsigned lag;
      w = active_width();
      h = active_height();
      lag = 2 * w + 2;
      if (cmd == CMD_PIXEL) begin
         line_rows[in_slot][in_col] = px;
         in_col++;
         if (in_col >= w) begin
            in_col = 0;
            in_slot = (in_slot + 1) % RING_ROWS;
            in_row++;
            if (in_row >= h) in_row = 0;
         end
         backlog++;
         if (backlog > lag) expected_responses.push_back(next_corner_response());
      end else if (backlog > in_row * w + in_col) begin
         expected_responses.push_back(next_corner_response());
      end
   endfunction

   // receiver: random stalls, optional long hold, and the response check
   always @(posedge clock) begin
      corner_result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_responses.size() == 0) begin
            report_mismatch("response with nothing expected");
         end else begin
            want = expected_responses.pop_front();
            if (rsp_ch.response !== want.response)
               report_mismatch($sformatf("response %0d, want %0d", rsp_ch.response,
                                         want.response));
            if (rsp_ch.is_corner !== want.is_corner)
               report_mismatch($sformatf("is_corner %b, want %b", rsp_ch.is_corner,
                                         want.is_corner));
            if (rsp_ch.pixel_row !== want.row)
               report_mismatch($sformatf("pixel_row %0d, want %0d", rsp_ch.pixel_row,
                                         want.row));
            if (rsp_ch.pixel_col !== want.col)
               report_mismatch($sformatf("pixel_col %0d, want %0d", rsp_ch.pixel_col,
                                         want.col));
            if (rsp_ch.frame_end !== want.frame_end)
               report_mismatch($sformatf("frame_end %b, want %b", rsp_ch.frame_end,
                                         want.frame_end));
         end
         stall_left = $urandom_range(0, rsp_max_gap);
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   task automatic send_request(input logic cmd, input logic [PIX_W-1:0] px);
      int gap;
      gap = $urandom_range(0, req_max_gap);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.cmd <= cmd;
      req_ch.gray_pixel <= px;
      do @(posedge clock); while (!req_ch.ready);
      predict_request(cmd, px);
      request_count++;
   endtask

   task automatic wait_for_responses();
      req_ch.valid <= 1'b0;
      while (expected_responses.size() > 0) @(posedge clock);
      // requests without a response may still be in the pipeline
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input csr_index_type idx, input logic [CSR_DATA_W-1:0] data);
      wait_for_responses();
      csr_wen <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_wen <= 1'b0;
      case (idx)
         CSR_FRAME_WIDTH: begin
            cfg_width = int'(data[GEOM_W-1:0]);
            restart_stream();
         end
         CSR_FRAME_HEIGHT: begin
            cfg_height = int'(data[GEOM_W-1:0]);
            restart_stream();
         end
         CSR_RESPONSE_THRESHOLD: cfg_threshold = longint'(data[RESP_W-1:0]);
         CSR_TRACE_WEIGHT: cfg_weight = int'(data[WEIGHT_W-1:0]);
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic set_geometry(input int w, input int h);
      csr_write(CSR_FRAME_WIDTH, CSR_DATA_W'(w));
      csr_write(CSR_FRAME_HEIGHT, CSR_DATA_W'(h));
   endtask

   // style 0 random, 1 two-level tiles, 2 black and white checker, 3 flat
   function automatic logic [PIX_W-1:0] pattern_pixel(input int style, input int r, input int c);
      case (style)
         1: return (((r / 2) + (c / 2)) % 2) ? tile_hi[7:0] : tile_lo[7:0];
         2: return ((r + c) % 2) ? 8'hFF : 8'h00;
         3: return tile_hi[7:0];
         default: return PIX_W'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic send_pixels(input int count, input int style);
      int i;
      for (i = 0; i < count; i++)
         send_request(CMD_PIXEL, pattern_pixel(style, int'(in_row), int'(in_col)));
   endtask

   task automatic flush_frame();
      while (backlog > in_row * active_width() + in_col)
         send_request(CMD_FLUSH, PIX_W'($urandom_range(0, 255)));
   endtask

   task automatic send_frame(input int style);
      tile_lo = $urandom_range(0, 255);
      tile_hi = $urandom_range(0, 255);
      send_pixels(active_width() * active_height(), style);
      flush_frame();
   endtask

   task automatic test_flush_without_frame();
      send_request(CMD_FLUSH, 8'hFF);
      send_request(CMD_FLUSH, 8'h00);
      send_pixels(5, 0);
      send_request(CMD_FLUSH, 8'h5A);
      wait_for_responses();
   endtask

   task automatic test_smallest_frame();
      set_geometry(3, 3);
      csr_write(CSR_RESPONSE_THRESHOLD, '0);
      csr_write(CSR_TRACE_WEIGHT, '0);
      send_frame(2);
      send_frame(3);
      csr_write(CSR_TRACE_WEIGHT, 16'hFFFF);
      send_frame(0);
   endtask

   task automatic test_weight_and_threshold_extremes();
      set_geometry(5, 4);
      csr_write(CSR_RESPONSE_THRESHOLD, '0);
      csr_write(CSR_TRACE_WEIGHT, 16'hFFFF);
      send_frame(1);
      csr_write(CSR_TRACE_WEIGHT, 16'd2621);
      send_frame(2);
      csr_write(CSR_RESPONSE_THRESHOLD, {CSR_DATA_W{1'b1}});
      send_frame(2);
      csr_write(CSR_RESPONSE_THRESHOLD, 47'd10000);
   endtask

   task automatic test_restart_mid_frame();
      set_geometry(6, 5);
      send_pixels(20, 0);
      wait_for_responses();
      csr_write(CSR_FRAME_WIDTH, 47'd6);
      send_frame(1);
      // back to back frames, flushed only at the end
      send_pixels(60, 0);
      flush_frame();
   endtask

   task automatic test_clamped_geometry();
      set_geometry(0, 0);
      send_frame(0);
      req_max_gap = 0;
      rsp_max_gap = 0;
      set_geometry(1, 2047);
      send_pixels(40, 0);
      wait_for_responses();
      set_geometry(4, 1);
      send_frame(1);
      req_max_gap = 13;
      rsp_max_gap = 13;
   endtask

   task automatic test_output_backpressure();
      set_geometry(8, 6);
      req_max_gap = 0;
      wait_for_responses();
      hold_left = 600;
      send_frame(1);
      req_max_gap = 13;
      wait_for_responses();
   endtask

   task automatic test_random_frames();
      int target;
      target = request_count + 200;
      while (request_count < target) begin
         if ($urandom_range(0, 3) == 0) begin
            req_max_gap = 0;
            rsp_max_gap = 0;
         end else begin
            req_max_gap = 13;
            rsp_max_gap = 13;
         end
         if ($urandom_range(0, 2) == 0)
            csr_write(CSR_RESPONSE_THRESHOLD, ($urandom_range(0, 4) == 0) ?
                      CSR_DATA_W'({$urandom, $urandom}) :
                      CSR_DATA_W'($urandom_range(0, 200000)));
         if ($urandom_range(0, 2) == 0)
            csr_write(CSR_TRACE_WEIGHT, ($urandom_range(0, 3) == 0) ?
                      CSR_DATA_W'($urandom_range(0, 65535)) :
                      CSR_DATA_W'($urandom_range(1000, 10000)));
         set_geometry($urandom_range(3, 12), $urandom_range(3, 8));
         if ($urandom_range(0, 6) == 0) begin
            // broken frame, dropped by the next geometry write
            send_pixels($urandom_range(1, active_width() * active_height() - 1),
                        $urandom_range(0, 1));
            if ($urandom_range(0, 1)) send_request(CMD_FLUSH, PIX_W'($urandom_range(0, 255)));
            wait_for_responses();
         end else begin
            send_frame($urandom_range(0, 3) == 0 ? $urandom_range(2, 3) :
                       $urandom_range(0, 1));
         end
      end
      req_max_gap = 13;
      rsp_max_gap = 13;
   endtask

   initial begin
      int i;
      reset = 1'b1;
      csr_wen = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_ch.valid = 1'b0;
      req_ch.cmd = CMD_PIXEL;
      req_ch.gray_pixel = '0;
      error_count = 0;
      request_count = 0;
      req_max_gap = 13;
      rsp_max_gap = 13;
      hold_left = 0;
      stall_left = 0;
      for (i = 0; i < RING_ROWS * MAX_LINE_WIDTH; i++)
         line_rows[i / MAX_LINE_WIDTH][i % MAX_LINE_WIDTH] = '0;
      cfg_width = 640;
      cfg_height = 480;
      cfg_threshold = 10000;
      cfg_weight = 2621;
      restart_stream();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_flush_without_frame();
      test_smallest_frame();
      test_weight_and_threshold_extremes();
      test_restart_mid_frame();
      test_output_backpressure();
      test_random_frames();
      test_clamped_geometry();
      wait_for_responses();

      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

### filelist.f
+incdir+hdl
hdl/hcr_pkg.sv
hdl/hcr_req_if.sv
hdl/hcr_line_store.sv
hdl/hcr_sequencer.sv
hdl/hcr_response_calc.sv
hdl/harris_corner_response.sv
hdl/hcr_checker.sv
dv/harris_corner_response_test.sv
